@@ hw/rtl/oss_pkg.sv @@
// Package for the obstacle scan steering block: codes, result struct,
// sweep angle table. No dependencies.
package oss_pkg;

    localparam int DIST_W  = 16;
    localparam int ANGLE_W = 8;
    localparam int MS_W    = 10;
    localparam int DIR_W   = 3;
    localparam int PHASE_W = 2;

    localparam logic [DIST_W-1:0] SAFE_DISTANCE_RESET = 16'd30;

    // Look directions: far left, left, left-front, centre, right-front, right, far right
    localparam logic [DIR_W-1:0] DIR_FAR_LEFT    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT        = 3'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT_FRONT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_CENTRE      = 3'd3;
    localparam logic [DIR_W-1:0] DIR_RIGHT_FRONT = 3'd4;
    localparam logic [DIR_W-1:0] DIR_RIGHT       = 3'd5;
    localparam logic [DIR_W-1:0] DIR_FAR_RIGHT   = 3'd6;

    typedef enum logic [2:0] {
        ACT_KEEP  = 3'd0,
        ACT_STOP  = 3'd1,
        ACT_LEFT  = 3'd2,
        ACT_RIGHT = 3'd3,
        ACT_REV   = 3'd4
    } motor_action_t;

    typedef struct packed {
        logic                servo_update;
        logic [ANGLE_W-1:0]  servo_angle;
        motor_action_t       motor_action;
        logic [MS_W-1:0]     action_ms;
        logic [DIR_W-1:0]    look_direction;
    } oss_result_t;

    // Servo angle for each sweep phase while the way ahead is clear
    function automatic logic [ANGLE_W-1:0] sweep_angle(input logic [PHASE_W-1:0] phase);
        logic [ANGLE_W-1:0] ang;
        unique case (phase)
            2'd0:    ang = 8'd135;
            2'd1:    ang = 8'd90;
            2'd2:    ang = 8'd45;
            default: ang = 8'd90;
        endcase
        return ang;
    endfunction

endpackage

@@ hw/rtl/oss_dist_if.sv @@
// Channel carrying one range measurement item.
// Depends on oss_pkg for widths.
interface oss_dist_if
    import oss_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

@@ hw/rtl/oss_res_if.sv @@
// Channel carrying one steering result item.
// Depends on oss_pkg for widths.
interface oss_res_if
    import oss_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               servo_update;
    logic [ANGLE_W-1:0] servo_angle;
    logic [2:0]         motor_action;
    logic [MS_W-1:0]    action_ms;
    logic [DIR_W-1:0]   look_direction;

    modport source (output valid, output servo_update, output servo_angle,
                    output motor_action, output action_ms, output look_direction,
                    input ready);
    modport sink   (input valid, input servo_update, input servo_angle,
                    input motor_action, input action_ms, input look_direction,
                    output ready);
endinterface

@@ hw/rtl/obstacle_scan_steering_fsm_core.sv @@
// Top level of the obstacle scan steering block: input register, config
// register, result register. Depends on oss_pkg, oss_dist_if, oss_res_if, oss_steer.
//
//   channel   dir   handshake        payload
//   meas      in    valid / ready    distance
//   res       out   valid / ready    servo_update, servo_angle, motor_action,
//                                    action_ms, look_direction
//   cfg       in    cfg_wr_en        cfg_wr_data (safe_distance)
//
// From acceptance to result valid an item passes the input register, loaded at the
// accepting edge, then the result register, which loads the decision from oss_steer.
// One item is taken every cycle unless stalled; only the result register can stall.
// rst_n clears both valid flags and the sweep phase, and sets the look direction
// to centre and safe_distance to 30. A stalled result holds its register and the
// input register keeps one more item before meas.ready drops.
module obstacle_scan_steering_fsm_core
    import oss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [DIST_W-1:0] cfg_wr_data,
    oss_dist_if.sink          meas,
    oss_res_if.source         res
);

    logic [DIST_W-1:0] safe_distance_reg;
    logic              in_valid_reg;
    logic [DIST_W-1:0] in_distance_reg;
    logic              out_valid_reg;
    oss_result_t       out_result_reg;
    oss_result_t       step_result;
    logic              out_load;
    logic              advance;

    // Move an item forward when the result register is free or draining
    assign out_load   = !out_valid_reg || res.ready;
    assign advance    = in_valid_reg && out_load;
    assign meas.ready = !in_valid_reg || out_load;

    // Hold the safe distance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            safe_distance_reg <= SAFE_DISTANCE_RESET;
        else if (cfg_wr_en)
            safe_distance_reg <= cfg_wr_data;
    end

    // Capture the incoming item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (meas.ready)
            in_valid_reg <= meas.valid;
    end

    always_ff @(posedge clk)
    begin
        if (meas.valid && meas.ready)
            in_distance_reg <= meas.distance;
    end

    oss_steer u_steer (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .distance      (in_distance_reg),
        .safe_distance (safe_distance_reg),
        .result        (step_result)
    );

    // Load or drain the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= step_result;
    end

    assign res.valid          = out_valid_reg;
    assign res.servo_update   = out_result_reg.servo_update;
    assign res.servo_angle    = out_result_reg.servo_angle;
    assign res.motor_action   = 3'(out_result_reg.motor_action);
    assign res.action_ms      = out_result_reg.action_ms;
    assign res.look_direction = out_result_reg.look_direction;

endmodule

@@ hw/rtl/oss_steer.sv @@
// Steering decision: look direction and sweep phase registers plus the
// per-reading decision table. Depends on oss_pkg.
module oss_steer
    import oss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [DIST_W-1:0] distance,
    input  logic [DIST_W-1:0] safe_distance,
    output oss_result_t       result
);

    logic [DIR_W-1:0]   direction_reg, direction_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               blocked;

    assign blocked = distance < safe_distance;

    // Decide servo and motor commands from direction and reading
    always_comb
    begin
        result.servo_update = 1'b1;
        result.servo_angle  = 8'd90;
        result.motor_action = ACT_KEEP;
        result.action_ms    = '0;
        direction_next      = DIR_CENTRE;
        phase_next          = phase_reg;
        unique case (direction_reg)
            DIR_CENTRE:
            begin
                if (blocked)
                begin
                    result.motor_action = ACT_STOP;
                    result.servo_angle  = 8'd120;
                    direction_next      = DIR_LEFT_FRONT;
                    phase_next          = '0;
                end
                else
                begin
                    result.servo_angle = sweep_angle(phase_reg);
                    phase_next         = phase_reg + 2'd1;
                end
            end
            DIR_LEFT_FRONT:
            begin
                if (blocked)
                begin
                    result.servo_angle = 8'd150;
                    direction_next     = DIR_LEFT;
                end
                else
                begin
                    result.motor_action = ACT_LEFT;
                    result.action_ms    = 10'd220;
                end
            end
            DIR_LEFT:
            begin
                if (blocked)
                begin
                    result.servo_angle = 8'd180;
                    direction_next     = DIR_FAR_LEFT;
                end
                else
                begin
                    result.motor_action = ACT_LEFT;
                    result.action_ms    = 10'd440;
                end
            end
            DIR_FAR_LEFT:
            begin
                if (blocked)
                begin
                    result.servo_angle = 8'd60;
                    direction_next     = DIR_RIGHT_FRONT;
                end
                else
                begin
                    result.motor_action = ACT_LEFT;
                    result.action_ms    = 10'd660;
                end
            end
            DIR_RIGHT_FRONT:
            begin
                if (blocked)
                begin
                    result.servo_angle = 8'd30;
                    direction_next     = DIR_RIGHT;
                end
                else
                begin
                    result.motor_action = ACT_RIGHT;
                    result.action_ms    = 10'd220;
                end
            end
            DIR_RIGHT:
            begin
                if (blocked)
                begin
                    result.servo_angle = 8'd0;
                    direction_next     = DIR_FAR_RIGHT;
                end
                else
                begin
                    result.motor_action = ACT_RIGHT;
                    result.action_ms    = 10'd440;
                end
            end
            DIR_FAR_RIGHT:
            begin
                if (blocked)
                begin
                    // reverse without moving the servo, then treat as left-front
                    result.servo_update = 1'b0;
                    result.servo_angle  = '0;
                    result.motor_action = ACT_REV;
                    result.action_ms    = 10'd300;
                    direction_next      = DIR_LEFT_FRONT;
                end
                else
                begin
                    result.motor_action = ACT_RIGHT;
                    result.action_ms    = 10'd700;
                end
            end
            default:
            begin
                // unreachable code: do nothing and hold it
                result.servo_update = 1'b0;
                result.servo_angle  = '0;
                direction_next      = direction_reg;
            end
        endcase
        result.look_direction = direction_next;
    end

    // Advance state when the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_CENTRE;
            phase_reg     <= '0;
        end
        else if (advance)
        begin
            direction_reg <= direction_next;
            phase_reg     <= phase_next;
        end
    end

endmodule
